// ----- design/gds_pkg.sv -----
package gds_pkg;

    localparam logic [2:0] MODE_RATE  = 3'd0;
    localparam logic [2:0] MODE_COEFF = 3'd1;
    localparam logic [2:0] MODE_POP   = 3'd2;
    localparam logic [2:0] MODE_STEP  = 3'd3;
    localparam logic [2:0] MODE_TIME  = 3'd4;

    localparam logic CFG_EVENTS = 1'b0;
    localparam logic CFG_VARS   = 1'b1;

    // controller -> datapath commands
    typedef struct packed {
        logic load_item;   // capture the input beat
        logic wr_rate;
        logic wr_coeff;
        logic wr_pop;
        logic wr_time;
        logic clr_acc;     // start of step: clear sum, index
        logic sum_acc;     // add rate[idx] to sum
        logic div_start;
        logic div_step;
        logic time_eval;   // compare and update time
        logic roul_start;  // build roulette value
        logic roul_step;   // compare/subtract one rate
        logic upd_step;    // update one population
        logic emit;        // load output register from pop[idx]
        logic idx_inc;
        logic idx_clr;
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic [2:0] mode;
        logic       idx_end_ev;   // idx reached events in use
        logic       idx_end_roul; // roulette idx at ne-1 or hit
        logic       idx_end_var;  // idx reached vars in use
        logic       sum_zero;
        logic       div_done;
        logic       fired;
        logic       clr_busy;     // stoich clearing pass after reset
    } t_sts;

endpackage

// ----- design/gillespie_direct_step.sv -----
// Channel  | dir | handshake              | payload
// s_axis   | in  | s_axis_tvalid/tready   | tuser: mode; tdata: event_index,var_index,
//          |     |                        |   rate_value,coeff_value,pop_value,limit_time,
//          |     |                        |   exp_draw,unif_draw
// m_axis   | out | m_axis_tvalid/tready   | tdata: new_time,chosen_event,event_fired,
//          |     |                        |   out_var_index,out_pop; tlast: last
// cfg      | in  | i_cfg_we               | i_cfg_idx, i_cfg_data
// Load beats pass through the decode state back to idle. A step sums the rates (an
// address and an accumulate state per rate, so each RAM read is waited out), runs the
// divide (one quotient bit a cycle), walks the roulette likewise, updates each variable
// and emits one beat per variable; with a zero sum no divide step, roulette or update
// runs. After reset the stoichiometry RAM is cleared, one entry a cycle (1024 entries
// at default size); s_axis_tready stays low, so every input beat waits for that pass.
// Result beats stall freely on m_axis_tready; one output register holds a beat.
module gillespie_direct_step #(
    parameter int MAX_EVENTS = 64,
    parameter int MAX_VARS   = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // [2:0] mode
    input  logic [2:0]    s_axis_tuser,
    // [5:0] event_index, [9:6] var_index, [41:10] rate_value,
    // [57:42] coeff_value, [89:58] pop_value, [153:90] limit_time,
    // [185:154] exp_draw, [217:186] unif_draw, zero pad to 224
    input  logic [223:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // [63:0] new_time, [69:64] chosen_event, [70] event_fired,
    // [74:71] out_var_index, [106:75] out_pop, zero pad to 112
    output logic [111:0]  m_axis_tdata,
    output logic          m_axis_tlast,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [6:0]    i_cfg_data
);
    gds_pkg::t_cmd w_cmd;
    gds_pkg::t_sts w_sts;
    logic          w_out_free;
    logic [63:0]   w_time;
    logic [5:0]    w_ev;
    logic          w_fired;
    logic [3:0]    w_vi;
    logic [31:0]   w_pop;

    gds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_out_free (w_out_free),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    gds_dp #(.MAX_EVENTS(MAX_EVENTS), .MAX_VARS(MAX_VARS)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_mode          (s_axis_tuser),
        .i_event_index   (s_axis_tdata[5:0]),
        .i_var_index     (s_axis_tdata[9:6]),
        .i_rate_value    (s_axis_tdata[41:10]),
        .i_coeff_value   (s_axis_tdata[57:42]),
        .i_pop_value     (s_axis_tdata[89:58]),
        .i_limit_time    (s_axis_tdata[153:90]),
        .i_exp_draw      (s_axis_tdata[185:154]),
        .i_unif_draw     (s_axis_tdata[217:186]),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_new_time      (w_time),
        .o_chosen_event  (w_ev),
        .o_event_fired   (w_fired),
        .o_out_var_index (w_vi),
        .o_out_pop       (w_pop),
        .o_last          (m_axis_tlast),
        .o_out_free      (w_out_free)
    );

    assign m_axis_tdata = {5'd0, w_pop, w_vi, w_fired, w_ev, w_time};
endmodule

// ----- design/gds_ram.sv -----
module gds_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/gds_ctrl.sv -----
module gds_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_out_free,   // output register empty or being taken
    input  gds_pkg::t_sts   i_sts,
    output gds_pkg::t_cmd   o_cmd
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_SUMA = 4'd2;  // address rate
    localparam logic [3:0] S_SUMB = 4'd3;  // data back, accumulate
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_TIME = 4'd5;
    localparam logic [3:0] S_RA   = 4'd6;
    localparam logic [3:0] S_RB   = 4'd7;
    localparam logic [3:0] S_UA   = 4'd8;
    localparam logic [3:0] S_UB   = 4'd9;
    localparam logic [3:0] S_EMIT = 4'd10;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        n_state    = r_state;
        case (r_state)
            S_IDLE: begin
                // hold off input until the stoich clearing pass is over
                o_in_ready = !i_sts.clr_busy;
                if (i_in_valid && !i_sts.clr_busy) begin
                    o_cmd.load_item = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                case (i_sts.mode)
                    gds_pkg::MODE_RATE:  begin o_cmd.wr_rate  = 1'b1; n_state = S_IDLE; end
                    gds_pkg::MODE_COEFF: begin o_cmd.wr_coeff = 1'b1; n_state = S_IDLE; end
                    gds_pkg::MODE_POP:   begin o_cmd.wr_pop   = 1'b1; n_state = S_IDLE; end
                    gds_pkg::MODE_TIME:  begin o_cmd.wr_time  = 1'b1; n_state = S_IDLE; end
                    gds_pkg::MODE_STEP:  begin o_cmd.clr_acc  = 1'b1; n_state = S_SUMA; end
                    default: n_state = S_IDLE;
                endcase
            end
            S_SUMA: begin
                if (i_sts.idx_end_ev) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else begin
                    n_state = S_SUMB;
                end
            end
            S_SUMB: begin
                o_cmd.sum_acc = 1'b1;
                o_cmd.idx_inc = 1'b1;
                n_state = S_SUMA;
            end
            S_DIV: begin
                if (i_sts.sum_zero || i_sts.div_done) begin
                    n_state = S_TIME;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_TIME: begin
                o_cmd.time_eval  = 1'b1;
                o_cmd.roul_start = 1'b1;
                o_cmd.idx_clr    = 1'b1;
                n_state = S_RA;
            end
            S_RA: begin
                if (!i_sts.fired) begin
                    n_state = S_EMIT;
                end else if (i_sts.idx_end_roul) begin
                    n_state = S_UA;
                    o_cmd.idx_clr = 1'b1;
                end else begin
                    n_state = S_RB;
                end
            end
            S_RB: begin
                o_cmd.roul_step = 1'b1;
                n_state = S_RA;
            end
            S_UA: begin
                if (i_sts.idx_end_var) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_UB;
                end
            end
            S_UB: begin
                o_cmd.upd_step = 1'b1;
                o_cmd.idx_inc  = 1'b1;
                n_state = S_UA;
            end
            S_EMIT: begin
                if (i_sts.idx_end_var) begin
                    n_state = S_IDLE;
                end else if (i_out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.idx_inc = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // roulette never runs for a step that did not fire
    a_no_roul_unfired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RB) |-> i_sts.fired) else $error("roulette without event");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_out_free) else $error("emit into full output");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == S_IDLE)) else $error("ready outside idle");
endmodule

// ----- design/gds_dp.sv -----
module gds_dp #(
    parameter int MAX_EVENTS = 64,
    parameter int MAX_VARS   = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gds_pkg::t_cmd   i_cmd,
    output gds_pkg::t_sts   o_sts,
    input  logic            i_cfg_we,
    input  logic            i_cfg_idx,
    input  logic [6:0]      i_cfg_data,
    input  logic [2:0]      i_mode,
    input  logic [5:0]      i_event_index,
    input  logic [3:0]      i_var_index,
    input  logic [31:0]     i_rate_value,
    input  logic [15:0]     i_coeff_value,
    input  logic [31:0]     i_pop_value,
    input  logic [63:0]     i_limit_time,
    input  logic [31:0]     i_exp_draw,
    input  logic [31:0]     i_unif_draw,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output logic [63:0]     o_new_time,
    output logic [5:0]      o_chosen_event,
    output logic            o_event_fired,
    output logic [3:0]      o_out_var_index,
    output logic [31:0]     o_out_pop,
    output logic            o_last,
    output logic            o_out_free
);
    localparam int EW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
    localparam int VW = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
    localparam int SW = 32 + EW + 1;
    localparam int CW = EW + VW;          // entry = event*MAX_VARS+var, MAX_VARS padded to 2^VW
    localparam int IW = (EW > VW ? EW : VW) + 1;

    // config
    logic [6:0] r_event_count;
    logic [4:0] r_var_count;
    logic [IW-1:0] w_ne, w_nv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_event_count <= '0;
            r_var_count   <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == gds_pkg::CFG_EVENTS) r_event_count <= i_cfg_data;
            else r_var_count <= i_cfg_data[4:0];
        end
    end

    assign w_ne = (32'(r_event_count) > MAX_EVENTS) ? IW'(MAX_EVENTS) : IW'(r_event_count);
    assign w_nv = (32'(r_var_count) > MAX_VARS) ? IW'(MAX_VARS) : IW'(r_var_count);

    // captured item
    logic [2:0]  r_mode;
    logic [5:0]  r_ev;
    logic [3:0]  r_vi;
    logic [31:0] r_rate_in;
    logic [15:0] r_coeff_in;
    logic [31:0] r_pop_in;
    logic [63:0] r_limit;
    logic [31:0] r_exp;
    logic [31:0] r_unif;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_mode     <= i_mode;
            r_ev       <= i_event_index;
            r_vi       <= i_var_index;
            r_rate_in  <= i_rate_value;
            r_coeff_in <= i_coeff_value;
            r_pop_in   <= i_pop_value;
            r_limit    <= i_limit_time;
            r_exp      <= i_exp_draw;
            r_unif     <= i_unif_draw;
        end
    end

    logic w_ev_ok, w_vi_ok;
    assign w_ev_ok = 32'(r_ev) < MAX_EVENTS;
    assign w_vi_ok = 32'(r_vi) < MAX_VARS;

    // index counter
    logic [IW-1:0] r_idx;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.clr_acc || i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc || i_cmd.roul_step) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // rate memory, reset cleared through valid bits
    logic [MAX_EVENTS-1:0] r_rate_vld;
    logic [31:0] w_rate_raw, w_rate;
    logic [EW-1:0] r_rd_ev;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_vld <= '0;
        end else if (i_cmd.wr_rate && w_ev_ok) begin
            r_rate_vld[r_ev[EW-1:0]] <= 1'b1;
        end
        r_rd_ev <= r_idx[EW-1:0];
    end

    gds_ram #(.WIDTH(32), .DEPTH(MAX_EVENTS)) u_rate (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_rate && w_ev_ok),
        .i_waddr (r_ev[EW-1:0]),
        .i_wdata (r_rate_in),
        .i_raddr (r_idx[EW-1:0]),
        .o_rdata (w_rate_raw)
    );
    assign w_rate = r_rate_vld[r_rd_ev] ? w_rate_raw : 32'd0;

    // stoichiometry memory; clearing pass after reset
    localparam int SD = 1 << CW;
    logic          r_clr_busy;
    logic [CW:0]   r_clr_ptr;
    logic [EW-1:0] r_chosen;
    logic          r_fired;
    logic [15:0]   w_coeff;
    logic          w_st_we;
    logic [CW-1:0] w_st_wa, w_st_ra;
    logic [15:0]   w_st_wd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_ptr  <= '0;
        end else if (r_clr_busy) begin
            r_clr_ptr <= r_clr_ptr + 1'b1;
            if (32'(r_clr_ptr) == SD - 1) r_clr_busy <= 1'b0;
        end
    end

    assign w_st_we = r_clr_busy || (i_cmd.wr_coeff && w_ev_ok && w_vi_ok);
    assign w_st_wa = r_clr_busy ? r_clr_ptr[CW-1:0]
                                : {r_ev[EW-1:0], r_vi[VW-1:0]};
    assign w_st_wd = r_clr_busy ? 16'd0 : r_coeff_in;
    assign w_st_ra = {r_chosen, r_idx[VW-1:0]};

    gds_ram #(.WIDTH(16), .DEPTH(SD)) u_stoich (
        .i_clk   (i_clk),
        .i_we    (w_st_we),
        .i_waddr (w_st_wa),
        .i_wdata (w_st_wd),
        .i_raddr (w_st_ra),
        .o_rdata (w_coeff)
    );

    // populations: per-variable registers, indexed by counter
    logic [31:0] r_pop [MAX_VARS];
    logic [VW-1:0] w_pi;
    logic [32:0] w_psum;
    logic [31:0] w_psat;
    assign w_pi   = r_idx[VW-1:0];
    assign w_psum = {r_pop[w_pi][31], r_pop[w_pi]} + {{17{w_coeff[15]}}, w_coeff};
    always_comb begin
        if (w_psum[32] != w_psum[31]) begin
            w_psat = w_psum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            w_psat = w_psum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_VARS; k++) r_pop[k] <= '0;
        end else if (i_cmd.wr_pop && w_vi_ok) begin
            r_pop[r_vi[VW-1:0]] <= r_pop_in;
        end else if (i_cmd.upd_step) begin
            r_pop[w_pi] <= w_psat;
        end
    end

    // rate sum
    logic [SW-1:0] r_sum;
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_acc) r_sum <= '0;
        else if (i_cmd.sum_acc) r_sum <= r_sum + SW'(w_rate);
    end

    // restoring divider, one quotient bit per cycle: (exp << 24) / sum
    logic [55:0]   r_dividend;
    logic [SW:0]   r_rem;
    logic [55:0]   r_quot;
    logic [5:0]    r_dcnt;
    logic [SW:0]   w_rsh;
    assign w_rsh = {r_rem[SW-1:0], r_dividend[55]};
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dividend <= {r_exp, 24'd0};
            r_rem      <= '0;
            r_quot     <= '0;
            r_dcnt     <= '0;
        end else if (i_cmd.div_step) begin
            r_dividend <= {r_dividend[54:0], 1'b0};
            r_dcnt     <= r_dcnt + 1'b1;
            if (w_rsh >= {1'b0, r_sum}) begin
                r_rem  <= w_rsh - {1'b0, r_sum};
                r_quot <= {r_quot[54:0], 1'b1};
            end else begin
                r_rem  <= w_rsh;
                r_quot <= {r_quot[54:0], 1'b0};
            end
        end
    end

    // time
    logic [63:0] r_time;
    logic [64:0] w_tsum;
    assign w_tsum = {1'b0, r_time} + {9'd0, r_quot};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
        end else if (i_cmd.wr_time) begin
            r_time <= r_limit;
        end else if (i_cmd.time_eval) begin
            if (r_sum == '0 || w_tsum[64] || w_tsum[63:0] >= r_limit) r_time <= r_limit;
            else r_time <= w_tsum[63:0];
        end
    end

    // roulette: p = floor(sum * u / 2^32), sum < 2^SW
    logic [SW+31:0] w_prod;
    logic [SW-1:0]  r_p;
    logic           r_hit;
    assign w_prod = r_sum * {{(SW){1'b0}}, r_unif};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fired <= 1'b0;
        end else if (i_cmd.time_eval) begin
            r_fired <= !(r_sum == '0 || w_tsum[64] || w_tsum[63:0] >= r_limit);
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.roul_start) begin
            r_p      <= w_prod[SW+31:32];
            r_hit    <= 1'b0;
            r_chosen <= '0;
        end else if (i_cmd.roul_step) begin
            if (r_p > SW'(w_rate)) begin
                r_p <= r_p - SW'(w_rate);
                r_chosen <= r_idx[EW-1:0] + 1'b1;
            end else begin
                r_hit <= 1'b1;
            end
        end
    end

    // output register
    logic        r_ov;
    logic [63:0] r_o_time;
    logic [5:0]  r_o_ev;
    logic        r_o_fired;
    logic [3:0]  r_o_vi;
    logic [31:0] r_o_pop;
    logic        r_o_last;
    assign o_out_free = !r_ov || i_out_ready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_time  <= r_time;
            r_o_ev    <= r_fired ? 6'(r_chosen) : 6'd0;
            r_o_fired <= r_fired;
            r_o_vi    <= 4'(r_idx);
            r_o_pop   <= r_pop[w_pi];
            r_o_last  <= (r_idx + 1'b1) == w_nv;
        end
    end
    assign o_out_valid     = r_ov;
    assign o_new_time      = r_o_time;
    assign o_chosen_event  = r_o_ev;
    assign o_event_fired   = r_o_fired;
    assign o_out_var_index = r_o_vi;
    assign o_out_pop       = r_o_pop;
    assign o_last          = r_o_last;

    // status; the controller keeps input off while the stoich clear runs
    assign o_sts.mode         = r_mode;
    assign o_sts.idx_end_ev   = r_idx == w_ne;
    assign o_sts.idx_end_roul = r_hit || (r_idx + 1'b1 >= w_ne);
    assign o_sts.idx_end_var  = r_idx == w_nv;
    assign o_sts.sum_zero     = r_sum == '0;
    assign o_sts.div_done     = r_dcnt == 6'd56;
    assign o_sts.fired        = r_fired;
    assign o_sts.clr_busy     = r_clr_busy;

    a_emit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_idx < w_nv)) else $error("emit past var count");
    a_fire_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.roul_step |-> (r_sum != '0)) else $error("roulette on zero sum");
    a_last_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && (r_idx + 1'b1) == w_nv) |=> o_last) else $error("last lost");
endmodule
